// ----- src/mfop_pkg.sv -----
`default_nettype none
package mfop_pkg;

	localparam int QDepth = 4;
	localparam int QPtrW = $clog2(QDepth);
	localparam int QCntW = $clog2(QDepth + 1);

	localparam logic [23:0] DefaultTempo = 24'd500000;

	localparam logic [7:0] MetaTempo = 8'h51;
	localparam logic [3:0] HiProgram = 4'hC;
	localparam logic [3:0] HiPressure = 4'hD;
	localparam logic [3:0] HiNoteOn = 4'h9;
	localparam logic [7:0] StSysex = 8'hF0;
	localparam logic [7:0] StEscape = 8'hF7;
	localparam logic [7:0] StMeta = 8'hFF;

	typedef enum logic [3:0] {
		PH_TAG, PH_HLEN, PH_HBODY, PH_CID, PH_CLEN, PH_DEAD, PH_SKIP, PH_DELTA,
		PH_STATUS, PH_DATA1, PH_DATA2, PH_MTYPE, PH_MLEN, PH_MDATA, PH_XLEN, PH_XDATA
	} phase_t;

	typedef struct packed {
		logic [7:0] file_byte;
		logic       end_of_file;
	} in_word_t;

	typedef struct packed {
		logic        kind;
		logic [31:0] tick;
		logic [23:0] tempo_us_per_quarter;
		logic [14:0] ticks_per_quarter;
		logic        file_valid;
		logic        last;
	} out_word_t;

	// one queue entry: what a single byte caused
	typedef struct packed {
		logic        has_onset;
		logic [31:0] onset_tick;
		logic        has_summary;
		logic [31:0] sum_tick;
		logic [23:0] sum_tempo;
		logic [14:0] sum_tpq;
		logic        sum_valid;
	} entry_t;

	function automatic logic [7:0] hdr_tag(input logic [1:0] i);
		case (i)
			2'd0: hdr_tag = 8'h4D;
			2'd1: hdr_tag = 8'h54;
			2'd2: hdr_tag = 8'h68;
			default: hdr_tag = 8'h64;
		endcase
	endfunction

	function automatic logic [7:0] trk_tag(input logic [1:0] i);
		case (i)
			2'd0: trk_tag = 8'h4D;
			2'd1: trk_tag = 8'h54;
			2'd2: trk_tag = 8'h72;
			default: trk_tag = 8'h6B;
		endcase
	endfunction

endpackage
`default_nettype wire

// ----- src/mfop_front.sv -----
`default_nettype none
module mfop_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              fire,
	input  wire mfop_pkg::in_word_t in_word,
	output logic                   push,
	output mfop_pkg::entry_t       push_entry
);
	import mfop_pkg::*;

	phase_t      phase_q, phase_n;
	logic [3:0]  fc_q, fc_n;
	logic [31:0] hlen_q, hlen_n;
	logic [31:0] cbl_q, cbl_n;
	logic        trk_q, trk_n;
	logic [31:0] abs_q, abs_n;
	logic [7:0]  rs_q, rs_n;
	logic [7:0]  cur_q, cur_n;
	logic [27:0] acc_q, acc_n;
	logic [2:0]  vcnt_q, vcnt_n;
	logic        meta51_q, meta51_n;
	logic [27:0] skip_q, skip_n;
	logic [23:0] tempo_q, tempo_n;
	logic        taken_q, taken_n;
	logic [31:0] longest_q, longest_n;
	logic [14:0] div_q, div_n;
	logic        hgood_q, hgood_n;
	logic        seen_q, seen_n;

	logic [7:0]  b;
	logic [1:0]  fi;
	logic [27:0] acc7;
	logic [2:0]  cnt1;
	logic        vdone, vbad;
	logic        onset;
	logic [23:0] acc8;
	logic        fvalid;

	always_comb begin
		b = in_word.file_byte;
		fi = fc_q[1:0];
		acc7 = {acc_q[20:0], b[6:0]};
		cnt1 = vcnt_q + 3'd1;
		vdone = !b[7];
		vbad = b[7] && (cnt1 >= 3'd4);
		acc8 = {acc_q[15:0], b};
		onset = 1'b0;
		fvalid = 1'b0;
		phase_n = phase_q; fc_n = fc_q; hlen_n = hlen_q; cbl_n = cbl_q;
		trk_n = trk_q; abs_n = abs_q; rs_n = rs_q; cur_n = cur_q;
		acc_n = acc_q; vcnt_n = vcnt_q; meta51_n = meta51_q; skip_n = skip_q;
		tempo_n = tempo_q; taken_n = taken_q; longest_n = longest_q;
		div_n = div_q; hgood_n = hgood_q; seen_n = seen_q;
		push_entry = '0;

		if (phase_q >= PH_SKIP) begin
			cbl_n = cbl_q - 32'd1;
			case (phase_q)
				PH_DELTA, PH_MLEN, PH_XLEN: begin
					acc_n = acc7;
					vcnt_n = cnt1;
					if (vdone) begin
						if (phase_q == PH_DELTA) begin
							abs_n = abs_q + {4'd0, acc7};
							phase_n = PH_STATUS;
						end else begin
							skip_n = acc7;
							if (phase_q == PH_MLEN && !(meta51_q && acc7 == 28'd3))
								meta51_n = 1'b0;
							if (acc7 == 28'd0) begin
								acc_n = '0; vcnt_n = '0; phase_n = PH_DELTA;
							end else if (phase_q == PH_MLEN) begin
								acc_n = '0; phase_n = PH_MDATA;
							end else begin
								phase_n = PH_XDATA;
							end
						end
					end else if (vbad) begin
						phase_n = PH_SKIP;
					end
				end
				PH_STATUS: begin
					if (b[7]) begin
						if (b < StSysex) rs_n = b;
						if (b == StMeta) begin
							rs_n = '0; phase_n = PH_MTYPE;
						end else if (b == StSysex || b == StEscape) begin
							rs_n = '0; acc_n = '0; vcnt_n = '0; phase_n = PH_XLEN;
						end else begin
							cur_n = b; phase_n = PH_DATA1;
						end
					end else if (rs_q == 8'd0) begin
						phase_n = PH_SKIP;
					end else begin
						// running status: this byte is the first data byte
						cur_n = rs_q;
						if (rs_q[7:4] == HiProgram || rs_q[7:4] == HiPressure) begin
							acc_n = '0; vcnt_n = '0; phase_n = PH_DELTA;
						end else begin
							phase_n = PH_DATA2;
						end
					end
				end
				PH_DATA1: begin
					if (cur_q[7:4] == HiProgram || cur_q[7:4] == HiPressure) begin
						acc_n = '0; vcnt_n = '0; phase_n = PH_DELTA;
					end else begin
						phase_n = PH_DATA2;
					end
				end
				PH_DATA2: begin
					acc_n = '0; vcnt_n = '0; phase_n = PH_DELTA;
					onset = (cur_q[7:4] == HiNoteOn) && (b != 8'd0);
				end
				PH_MTYPE: begin
					meta51_n = (b == MetaTempo);
					acc_n = '0; vcnt_n = '0; phase_n = PH_MLEN;
				end
				PH_MDATA: begin
					if (meta51_q) acc_n = {4'd0, acc8};
					skip_n = skip_q - 28'd1;
					if (skip_n == 28'd0) begin
						if (meta51_q && !taken_q && acc8 != 24'd0) begin
							tempo_n = acc8; taken_n = 1'b1;
						end
						acc_n = '0; vcnt_n = '0; phase_n = PH_DELTA;
					end
				end
				PH_XDATA: begin
					skip_n = skip_q - 28'd1;
					if (skip_n == 28'd0) begin
						acc_n = '0; vcnt_n = '0; phase_n = PH_DELTA;
					end
				end
				default: ;
			endcase
			if (cbl_n == 32'd0) begin
				if (trk_q && abs_n > longest_q) longest_n = abs_n;
				phase_n = PH_CID;
				fc_n = '0;
			end
		end else begin
			case (phase_q)
				PH_TAG: begin
					if (b != hdr_tag(fi)) phase_n = PH_DEAD;
					else if (fi == 2'd3) begin
						fc_n = '0; phase_n = PH_HLEN;
					end else fc_n = {2'd0, fi} + 4'd1;
				end
				PH_HLEN: begin
					hlen_n = {hlen_q[23:0], b};
					if (fi == 2'd3) begin
						fc_n = '0;
						phase_n = (hlen_n < 32'd6) ? PH_DEAD : PH_HBODY;
					end else fc_n = {2'd0, fi} + 4'd1;
				end
				PH_HBODY: begin
					if (fc_q == 4'd4 && b[7]) begin
						phase_n = PH_DEAD;
					end else begin
						if (fc_q == 4'd4) div_n = {b[6:0], 8'd0};
						else if (fc_q == 4'd5) div_n = {div_q[14:8], b};
						if (fc_q < 4'd6) fc_n = fc_q + 4'd1;
						hlen_n = hlen_q - 32'd1;
						if (hlen_n == 32'd0) begin
							if (div_n == 15'd0) phase_n = PH_DEAD;
							else begin
								hgood_n = 1'b1; phase_n = PH_CID; fc_n = '0;
							end
						end
					end
				end
				PH_CID: begin
					if (fi == 2'd0) trk_n = (b == trk_tag(fi));
					else if (b != trk_tag(fi)) trk_n = 1'b0;
					if (fi == 2'd3) begin
						fc_n = '0; cbl_n = '0; phase_n = PH_CLEN;
					end else fc_n = {2'd0, fi} + 4'd1;
				end
				PH_CLEN: begin
					cbl_n = {cbl_q[23:0], b};
					if (fi != 2'd3) fc_n = {2'd0, fi} + 4'd1;
					else begin
						fc_n = '0;
						if (trk_q) begin
							seen_n = 1'b1; abs_n = '0; rs_n = '0;
							acc_n = '0; vcnt_n = '0; phase_n = PH_DELTA;
						end else phase_n = PH_SKIP;
						if (cbl_n == 32'd0) begin
							if (trk_q && abs_n > longest_q) longest_n = abs_n;
							phase_n = PH_CID;
						end
					end
				end
				default: ;
			endcase
		end

		push_entry.has_onset = onset;
		push_entry.onset_tick = abs_n;

		if (in_word.end_of_file) begin
			fvalid = hgood_n & seen_n;
			if (trk_n && abs_n > longest_n) longest_n = abs_n;
			push_entry.has_summary = 1'b1;
			push_entry.sum_valid = fvalid;
			push_entry.sum_tick = fvalid ? longest_n : 32'd0;
			push_entry.sum_tempo = fvalid ? tempo_n : DefaultTempo;
			push_entry.sum_tpq = fvalid ? div_n : 15'd0;
			// back to the start of a new file
			phase_n = PH_TAG; fc_n = '0; hlen_n = '0; cbl_n = '0; trk_n = 1'b0;
			abs_n = '0; rs_n = '0; cur_n = '0; acc_n = '0; vcnt_n = '0;
			meta51_n = 1'b0; skip_n = '0; tempo_n = DefaultTempo; taken_n = 1'b0;
			longest_n = '0; div_n = '0; hgood_n = 1'b0; seen_n = 1'b0;
		end
		push = fire && (onset || in_word.end_of_file);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TAG; fc_q <= '0; hlen_q <= '0; cbl_q <= '0; trk_q <= 1'b0;
			abs_q <= '0; rs_q <= '0; cur_q <= '0; acc_q <= '0; vcnt_q <= '0;
			meta51_q <= 1'b0; skip_q <= '0; tempo_q <= DefaultTempo; taken_q <= 1'b0;
			longest_q <= '0; div_q <= '0; hgood_q <= 1'b0; seen_q <= 1'b0;
		end else if (fire) begin
			phase_q <= phase_n; fc_q <= fc_n; hlen_q <= hlen_n; cbl_q <= cbl_n;
			trk_q <= trk_n; abs_q <= abs_n; rs_q <= rs_n; cur_q <= cur_n;
			acc_q <= acc_n; vcnt_q <= vcnt_n; meta51_q <= meta51_n; skip_q <= skip_n;
			tempo_q <= tempo_n; taken_q <= taken_n; longest_q <= longest_n;
			div_q <= div_n; hgood_q <= hgood_n; seen_q <= seen_n;
		end
	end

endmodule
`default_nettype wire

// ----- src/mfop_queue.sv -----
`default_nettype none
module mfop_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire mfop_pkg::entry_t push_entry,
	output logic                  not_full,
	output logic                  not_empty,
	input  wire logic             pop,
	output mfop_pkg::entry_t      head
);
	import mfop_pkg::*;

	entry_t           mem_q [QDepth];
	logic [QPtrW-1:0] wr_q, rd_q;
	logic [QCntW-1:0] cnt_q;

	assign not_full = (cnt_q != QCntW'(QDepth));
	assign not_empty = (cnt_q != '0);
	assign head = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + QPtrW'(1);
			if (pop) rd_q <= rd_q + QPtrW'(1);
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + QCntW'(1);
				2'b01: cnt_q <= cnt_q - QCntW'(1);
				default: ;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCntW'(QDepth)) else $error("queue count out of range");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> not_full) else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty) else $error("pop from empty queue");
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + QCntW'(1))
		else $error("count did not follow push");
`endif

endmodule
`default_nettype wire

// ----- src/mfop_back.sv -----
`default_nettype none
module mfop_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             not_empty,
	input  wire mfop_pkg::entry_t head,
	output logic                  pop,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output mfop_pkg::out_word_t   out_data
);
	import mfop_pkg::*;

	out_word_t out_q, out_n;
	logic      valid_q, valid_n;
	logic      sent_q, sent_n;
	logic      load;

	always_comb begin
		load = !valid_q || out_ready;
		out_n = out_q;
		valid_n = valid_q && !out_ready;
		sent_n = sent_q;
		pop = 1'b0;
		if (load && not_empty) begin
			valid_n = 1'b1;
			out_n = '0;
			if (head.has_onset && !sent_q) begin
				out_n.kind = 1'b0;
				out_n.tick = head.onset_tick;
				out_n.last = !head.has_summary;
				if (head.has_summary) sent_n = 1'b1;
				else pop = 1'b1;
			end else begin
				out_n.kind = 1'b1;
				out_n.tick = head.sum_tick;
				out_n.tempo_us_per_quarter = head.sum_tempo;
				out_n.ticks_per_quarter = head.sum_tpq;
				out_n.file_valid = head.sum_valid;
				out_n.last = 1'b1;
				sent_n = 1'b0;
				pop = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		out_q <= out_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sent_q <= 1'b0;
		end else begin
			valid_q <= valid_n;
			sent_q <= sent_n;
		end
	end

	assign out_valid = valid_q;
	assign out_data = out_q;

endmodule
`default_nettype wire

// ----- src/midi_file_onset_parser.sv -----
// midi file onset parser
// in channel: one file byte per word (file_byte, end_of_file marks the last
// byte of a file). out channel: result words, an onset (kind 0) for every
// note-on with nonzero velocity, and a summary (kind 1) on the last byte,
// carrying validity, division, longest track tick and first tempo.
// last is set on the final word caused by one input byte.
// throughput: one input byte per cycle while the result queue has room; the
// parser state advances in the cycle a byte is taken. a byte that causes two
// words (onset and summary) sends both from one queue entry, onset first.
// path: a result word is written into the result queue when its byte is
// taken, then moved from the queue into the output register.
// a four-entry queue between the parser and the output register lets the
// parser keep taking bytes while the receiver stalls; in_ready drops only
// when that queue is full.
// reset: parser returns to the header tag state with default tempo,
// queue and output are emptied. after each end_of_file byte the parser
// also returns to that state, ready for the next file.
`default_nettype none
module midi_file_onset_parser (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire mfop_pkg::in_word_t  in_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output mfop_pkg::out_word_t      out_data
);
	import mfop_pkg::*;

	logic   fire;
	logic   push, pop, not_full, not_empty;
	entry_t push_entry, head;

	// a byte is taken whenever the result queue has room
	assign in_ready = not_full;
	assign fire = in_valid && not_full;

	mfop_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.in_word    (in_data),
		.push       (push),
		.push_entry (push_entry)
	);

	mfop_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.not_full   (not_full),
		.not_empty  (not_empty),
		.pop        (pop),
		.head       (head)
	);

	// back end turns each queue entry into one or two output words
	mfop_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.not_empty (not_empty),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire
